>>> rtl/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Depends on nothing; every other file in rtl imports it.
package i2cmbe_pkg;

	// Default width of the wait counter.
	localparam int COUNT_BITS_DEF = 16;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int CFG_W      = 16;

	// Register reset values.
	localparam logic [CFG_W-1:0] HALF_PERIOD_RST     = 16'd5;
	localparam logic [CFG_W-1:0] STRETCH_TIMEOUT_RST = 16'd255;

	// Command codes carried in the mode field.
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_READ  = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	// Register indexes, taken from word address bit 2.
	typedef enum logic {
		REG_HALF_PERIOD     = 1'b0,
		REG_STRETCH_TIMEOUT = 1'b1
	} reg_idx_t;

	// Configuration registers as seen by the bit engine.
	typedef struct packed {
		logic [CFG_W-1:0] half_period;
		logic [CFG_W-1:0] stretch_timeout;
	} cfg_t;

	// One tick item.
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       scl_sense;
		logic       sda_sense;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       scl_pull;
		logic       sda_pull;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       timed_out;
	} result_t;

	// Wait points of the four command sequences. D is a half-period delay,
	// S a clock-stretch wait, END the closing step of a command.
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_START_D1, PH_START_D3, PH_START_S4, PH_START_D6,
		PH_WR_D0, PH_WR_D3, PH_WR_D5, PH_WR_S6,
		PH_WR_D10, PH_WR_D12, PH_WR_S13, PH_WR_D15,
		PH_RD_D0, PH_RD_D2, PH_RD_D4, PH_RD_S5,
		PH_RD_D8, PH_RD_D11, PH_RD_D13, PH_RD_S14,
		PH_SP_D0, PH_SP_D2, PH_SP_D4, PH_SP_S5, PH_SP_D7,
		PH_END, PH_END_SCL, PH_END_RD
	} phase_t;

endpackage

>>> rtl/i2cmbe_cfg_regs.sv
// Configuration registers of the I2C master bit engine behind an APB-style port.
// Depends on i2cmbe_pkg for the register map and the cfg_t bundle.
module i2cmbe_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2cmbe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [i2cmbe_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [i2cmbe_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready,
	output i2cmbe_pkg::cfg_t                    cfg
);
	import i2cmbe_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	// Registers are word aligned; bit 2 picks the register.
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register write on the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period     <= HALF_PERIOD_RST;
			cfg_q.stretch_timeout <= STRETCH_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_HALF_PERIOD:     cfg_q.half_period     <= pwdata[CFG_W-1:0];
				REG_STRETCH_TIMEOUT: cfg_q.stretch_timeout <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	// Read data, zero extended to the bus width.
	always_comb begin
		unique case (reg_sel)
			REG_HALF_PERIOD:     prdata = APB_DATA_W'(cfg_q.half_period);
			REG_STRETCH_TIMEOUT: prdata = APB_DATA_W'(cfg_q.stretch_timeout);
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/i2cmbe_step.sv
// Per-tick sequencer of the I2C master bit engine: bus state, counters and the
// combinational step that turns one tick item into one result. Depends on i2cmbe_pkg.
module i2cmbe_step #(
	parameter int COUNT_BITS = i2cmbe_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  i2cmbe_pkg::item_t     item,
	input  i2cmbe_pkg::cfg_t      cfg,
	output i2cmbe_pkg::result_t   result
);
	import i2cmbe_pkg::*;

	localparam logic [31:0]           CNT_CAP = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	// State registers.
	phase_t                phase_q;
	logic                  pend_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [2:0]            bit_idx_q;
	logic [7:0]            shift_q;
	logic                  ack_tx_q;
	logic                  scl_q;
	logic                  sda_q;
	logic                  ack_seen_q;
	logic                  timed_out_q;
	logic [7:0]            rx_q;

	// Working values of the current tick.
	phase_t                ph;
	phase_t                nxt_ph;
	phase_t                phase_d;
	logic                  pend;
	logic                  pend_d;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [2:0]            bit_idx;
	logic [7:0]            shift;
	logic                  ack_tx;
	logic                  scl;
	logic                  sda;
	logic                  ack_seen;
	logic                  timed_out;
	logic [7:0]            rx;
	logic                  done;
	logic                  is_stretch;
	logic                  is_end;
	logic                  is_loop;
	logic                  nxt_stretch;

	// Wait lengths, clamped to the counter width; a zero half period acts as one.
	logic [CFG_W-1:0]      hp_min;
	logic [31:0]           hp_ext;
	logic [31:0]           st_ext;
	logic [COUNT_BITS-1:0] hp_load;
	logic [COUNT_BITS-1:0] st_load;

	assign hp_min  = (cfg.half_period == '0) ? CFG_W'(1) : cfg.half_period;
	assign hp_ext  = 32'(hp_min);
	assign st_ext  = 32'(cfg.stretch_timeout);
	assign hp_load = COUNT_BITS'((hp_ext > CNT_CAP) ? CNT_CAP : hp_ext);
	assign st_load = COUNT_BITS'((st_ext > CNT_CAP) ? CNT_CAP : st_ext);

	// Next state and result of one tick.
	always_comb begin
		ph        = phase_q;
		pend      = pend_q;
		bit_idx   = bit_idx_q;
		shift     = shift_q;
		ack_tx    = ack_tx_q;
		scl       = scl_q;
		sda       = sda_q;
		ack_seen  = ack_seen_q;
		timed_out = timed_out_q;
		rx        = rx_q;
		done      = 1'b0;
		phase_d   = phase_q;
		pend_d    = pend_q;
		cnt_d     = cnt_q;
		nxt_ph    = PH_IDLE;
		is_loop   = 1'b0;

		// An idle engine takes a command from the item and runs it on this tick.
		if (phase_q == PH_IDLE) begin
			pend = 1'b1;
			unique case (item.mode)
				MODE_NONE:  ph = PH_IDLE;
				MODE_START: ph = PH_START_D1;
				MODE_WRITE: ph = PH_WR_D0;
				MODE_READ:  ph = PH_RD_D0;
				MODE_STOP:  ph = PH_SP_D0;
				default:    ph = PH_IDLE;
			endcase
			if (ph != PH_IDLE) begin
				ack_seen  = 1'b0;
				timed_out = 1'b0;
				bit_idx   = 3'd7;
			end
			if (item.mode == MODE_WRITE) begin
				shift = item.tx_byte;
			end
			if (item.mode == MODE_READ) begin
				ack_tx = item.send_ack;
			end
		end

		// Line changes and samples that open a wait point.
		if (pend) begin
			unique case (ph)
				PH_START_D1: sda = 1'b0;
				PH_START_D3: scl = 1'b0;
				PH_START_D6: sda = 1'b1;
				PH_WR_D3: begin
					scl = 1'b1;
					sda = ~shift[bit_idx];
				end
				PH_WR_D5:    scl = 1'b0;
				PH_WR_D10: begin
					scl = 1'b1;
					sda = 1'b0;
				end
				PH_WR_D12:   scl = 1'b0;
				PH_WR_D15: begin
					if (!item.sda_sense) begin
						ack_seen = 1'b1;
					end
				end
				PH_RD_D2:    scl = 1'b1;
				PH_RD_D4:    scl = 1'b0;
				PH_RD_D8: begin
					shift = {shift[6:0], item.sda_sense};
					scl   = 1'b1;
				end
				PH_RD_D11: begin
					rx = shift;
					if (ack_tx) begin
						sda = 1'b1;
					end
				end
				PH_RD_D13:   scl = 1'b0;
				PH_SP_D2:    sda = 1'b1;
				PH_SP_D4:    scl = 1'b0;
				PH_SP_D7:    sda = 1'b0;
				PH_END_SCL:  scl = 1'b1;
				PH_END_RD: begin
					scl = 1'b1;
					sda = 1'b0;
				end
				default: ;
			endcase
		end

		// Kind of wait point.
		unique case (ph) inside
			PH_START_S4, PH_WR_S6, PH_WR_S13, PH_RD_S5, PH_RD_S14, PH_SP_S5: begin
				is_stretch = 1'b1;
				is_end     = 1'b0;
			end
			PH_END, PH_END_SCL, PH_END_RD: begin
				is_stretch = 1'b0;
				is_end     = 1'b1;
			end
			default: begin
				is_stretch = 1'b0;
				is_end     = 1'b0;
			end
		endcase

		// Following wait point; the bit loops close after a stretch or delay.
		unique case (ph)
			PH_START_D1: nxt_ph = PH_START_D3;
			PH_START_D3: nxt_ph = PH_START_S4;
			PH_START_S4: nxt_ph = PH_START_D6;
			PH_START_D6: nxt_ph = PH_END;
			PH_WR_D0:    nxt_ph = PH_WR_D3;
			PH_WR_D3:    nxt_ph = PH_WR_D5;
			PH_WR_D5:    nxt_ph = PH_WR_S6;
			PH_WR_S6: begin
				is_loop = 1'b1;
				nxt_ph  = (bit_idx != 3'd0) ? PH_WR_D3 : PH_WR_D10;
			end
			PH_WR_D10:   nxt_ph = PH_WR_D12;
			PH_WR_D12:   nxt_ph = PH_WR_S13;
			PH_WR_S13:   nxt_ph = PH_WR_D15;
			PH_WR_D15:   nxt_ph = PH_END_SCL;
			PH_RD_D0:    nxt_ph = PH_RD_D2;
			PH_RD_D2:    nxt_ph = PH_RD_D4;
			PH_RD_D4:    nxt_ph = PH_RD_S5;
			PH_RD_S5:    nxt_ph = PH_RD_D8;
			PH_RD_D8: begin
				is_loop = 1'b1;
				nxt_ph  = (bit_idx != 3'd0) ? PH_RD_D4 : PH_RD_D11;
			end
			PH_RD_D11:   nxt_ph = PH_RD_D13;
			PH_RD_D13:   nxt_ph = PH_RD_S14;
			PH_RD_S14:   nxt_ph = PH_END_RD;
			PH_SP_D0:    nxt_ph = PH_SP_D2;
			PH_SP_D2:    nxt_ph = PH_SP_D4;
			PH_SP_D4:    nxt_ph = PH_SP_S5;
			PH_SP_S5:    nxt_ph = PH_SP_D7;
			PH_SP_D7:    nxt_ph = PH_END;
			default:     nxt_ph = PH_IDLE;
		endcase

		// Every stretch wait directly follows a delay.
		unique case (nxt_ph) inside
			PH_START_S4, PH_WR_S6, PH_WR_S13, PH_RD_S5, PH_RD_S14, PH_SP_S5:
				nxt_stretch = 1'b1;
			default:
				nxt_stretch = 1'b0;
		endcase

		// A delay loads its count on its first tick; a stretch wait gets its
		// limit on the last tick of the delay before it.
		if (pend && !is_stretch) begin
			cnt_cur = hp_load;
		end else begin
			cnt_cur = cnt_q;
		end

		// One tick of the wait, or the closing step.
		if (ph == PH_IDLE) begin
			phase_d = PH_IDLE;
		end else if (is_end) begin
			phase_d = PH_IDLE;
			pend_d  = 1'b0;
			done    = 1'b1;
		end else if (is_stretch && (cnt_cur != '0) && item.scl_sense) begin
			phase_d = nxt_ph;
			pend_d  = 1'b1;
			if (is_loop && (bit_idx != 3'd0)) begin
				bit_idx = bit_idx - 3'd1;
			end
		end else if (is_stretch && (cnt_cur <= CNT_ONE)) begin
			// Clock stretch ran out: the command ends with SCL released.
			timed_out = 1'b1;
			phase_d   = PH_IDLE;
			pend_d    = 1'b0;
			done      = 1'b1;
		end else if (is_stretch || (cnt_cur > CNT_ONE)) begin
			cnt_d   = cnt_cur - CNT_ONE;
			phase_d = ph;
			pend_d  = 1'b0;
		end else begin
			phase_d = nxt_ph;
			pend_d  = 1'b1;
			if (nxt_stretch) begin
				cnt_d = st_load;
			end
			if (is_loop && (bit_idx != 3'd0)) begin
				bit_idx = bit_idx - 3'd1;
			end
		end

		result.scl_pull  = scl;
		result.sda_pull  = sda;
		result.busy      = (phase_d != PH_IDLE);
		result.done      = done;
		result.rx_byte   = rx;
		result.ack_seen  = ack_seen;
		result.timed_out = timed_out;
	end

	// Sequencer state and bus levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pend_q      <= 1'b0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			ack_seen_q  <= 1'b0;
			timed_out_q <= 1'b0;
			rx_q        <= '0;
		end else if (en) begin
			phase_q     <= phase_d;
			pend_q      <= pend_d;
			scl_q       <= scl;
			sda_q       <= sda;
			ack_seen_q  <= ack_seen;
			timed_out_q <= timed_out;
			rx_q        <= rx;
		end
	end

	// Counters and the data shifter.
	always_ff @(posedge clk) begin
		if (en) begin
			cnt_q     <= cnt_d;
			bit_idx_q <= bit_idx;
			shift_q   <= shift;
			ack_tx_q  <= ack_tx;
		end
	end

endmodule

>>> rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: tick input register, sequencer,
// result register and configuration port. Depends on i2cmbe_pkg,
// i2cmbe_cfg_regs and i2cmbe_step.
//
//   Port group   Handshake                      Payload
//   tick in      in_valid / in_ready            mode, tx_byte, send_ack, scl_sense, sda_sense
//   result out   out_valid / out_ready          scl_pull, sda_pull, busy_res, done_res,
//                                               rx_byte, ack_seen, timed_out
//   config       psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One tick item is taken per cycle unless a held result stalls the input; the
// tick register feeds the combinational sequencer step, whose result is captured
// in the result register. Reset clears the sequencer to idle with both lines
// released and the registers at their defaults. When a tick is registered and
// the result register is full and not taken, the tick register holds and
// in_ready drops until the result moves on.
module i2c_master_bit_engine #(
	parameter int COUNT_BITS = i2cmbe_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [i2cmbe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [i2cmbe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [i2cmbe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         mode,
	input  logic [7:0]                         tx_byte,
	input  logic                               send_ack,
	input  logic                               scl_sense,
	input  logic                               sda_sense,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               scl_pull,
	output logic                               sda_pull,
	output logic                               busy_res,
	output logic                               done_res,
	output logic [7:0]                         rx_byte,
	output logic                               ack_seen,
	output logic                               timed_out
);
	import i2cmbe_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_res;
	result_t res_q;
	logic    out_valid_q;
	logic    step_en;

	i2cmbe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A registered tick steps the sequencer whenever the result slot is free or being taken.
	assign step_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	// Tick input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode      <= mode;
			item_s1.tx_byte   <= tx_byte;
			item_s1.send_ack  <= send_ack;
			item_s1.scl_sense <= scl_sense;
			item_s1.sda_sense <= sda_sense;
		end
	end

	i2cmbe_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_pull  = res_q.scl_pull;
	assign sda_pull  = res_q.sda_pull;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign rx_byte   = res_q.rx_byte;
	assign ack_seen  = res_q.ack_seen;
	assign timed_out = res_q.timed_out;

	// A finished command never reports itself as still running.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.done && res_q.busy))
		else $error("done and busy both set in one result");

	// The tick side only stalls behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a held result");

	// A taken result with no new step leaves the result slot empty.
	a_slot_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !step_en) |=> !out_valid_q)
		else $error("result slot not emptied after transfer");

	// After a stretch timeout SCL stays released until the next command.
	a_timeout_scl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.timed_out) |-> !res_q.scl_pull)
		else $error("SCL driven low while timeout flag is set");

endmodule
